>>> hw/rtl/tcw_pkg.sv
package tcw_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BLANK,
        ST_WRITE,
        ST_DONE
    } state_t;

    // cursor update request, at most one member high in a cycle
    typedef struct packed {
        logic home;
        logic jump;
        logic advance;
    } cursor_cmd_t;

    localparam logic       KIND_PUT  = 1'b0;
    localparam logic       KIND_READ = 1'b1;

    localparam logic       REG_HIGH_NIBBLE = 1'b0;
    localparam logic       REG_LOW_NIBBLE  = 1'b1;

    localparam logic [3:0] HIGH_NIBBLE_RESET = 4'd2;
    localparam logic [3:0] LOW_NIBBLE_RESET  = 4'd8;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] BLANK_ATTR   = 8'h0F;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] NULL_CODE    = 8'h00;

endpackage

>>> hw/rtl/text_console_cell_writer.sv
// channel  | direction | handshake          | payload
// s        | in        | s_tvalid/s_tready  | s_tuser kind, s_tdata char_code, read_index
// m        | out       | m_tvalid/m_tready  | m_tdata cursor_position, cell_char, cell_attribute
// cfg      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (colour nibbles)
//
// one transaction in flight; a read or a null code goes straight to the done state, a printable
// code through the write state, a newline through the blank state, which clears cells one by one
// on the single cell ram write port; a last-row newline or a put on a full screen blanks all cells
// reset clears the cursor and handshake state and reloads the reset colours; cell contents
// stay unknown until written
// the output register lets the next transaction in while a result waits on m_tready
module text_console_cell_writer #(
    parameter int SCREEN_CELLS = 2000,
    parameter int ROW_CELLS    = 80
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // char_code [7:0], read_index [18:8]
    input  logic        s_tuser,    // kind [0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // cursor_position [10:0], cell_char [18:11], cell_attribute [26:19]

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int AW = $clog2(SCREEN_CELLS);
    localparam int CW = $clog2(SCREEN_CELLS + 1);

    tcw_pkg::state_t      state_reg, state_next;
    tcw_pkg::cursor_cmd_t cur_cmd;

    logic [3:0]    high_nibble_reg;
    logic [3:0]    low_nibble_reg;

    logic [7:0]    code_reg;
    logic          kind_reg;
    logic          oob_reg;
    logic          write_after_reg;
    logic [CW-1:0] sweep_addr_reg;
    logic [CW-1:0] sweep_end_reg;

    logic          m_tvalid_reg;
    logic [10:0]   out_cursor_reg;
    logic [7:0]    out_char_reg;
    logic [7:0]    out_attr_reg;

    logic [CW-1:0] cursor;
    logic [CW:0]   next_row;
    logic [CW+10:0] cursor_ext;
    logic [AW+10:0] rd_idx_ext;

    logic          accept;
    logic          in_read;
    logic [7:0]    in_code;
    logic [10:0]   in_index;
    logic          is_newline;
    logic          is_null;
    logic          row_past;
    logic          cur_full;
    logic          sweep_last;
    logic          out_load;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wchar;
    logic [7:0]    ram_wattr;
    logic          ram_re;
    logic [7:0]    ram_rchar;
    logic [7:0]    ram_rattr;

    assign s_tready  = (state_reg == tcw_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign in_read    = (s_tuser == tcw_pkg::KIND_READ);
    assign in_code    = s_tdata[7:0];
    assign in_index   = s_tdata[18:8];
    assign is_newline = (in_code == tcw_pkg::NEWLINE_CODE);
    assign is_null    = (in_code == tcw_pkg::NULL_CODE);
    assign row_past   = (next_row >= (CW + 1)'(SCREEN_CELLS));
    assign cur_full   = (cursor >= CW'(SCREEN_CELLS));
    assign sweep_last = ((sweep_addr_reg + 1'b1) == sweep_end_reg);
    assign out_load   = (state_reg == tcw_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    assign rd_idx_ext = {AW'(0), in_index};
    assign cursor_ext = {11'b0, cursor};

    tcw_cursor #(
        .ROW_CELLS (ROW_CELLS),
        .CW        (CW)
    ) u_cursor (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cur_cmd),
        .cursor   (cursor),
        .next_row (next_row)
    );

    tcw_cell_ram #(
        .SCREEN_CELLS (SCREEN_CELLS),
        .AW           (AW)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_char (ram_wchar),
        .wr_attr (ram_wattr),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_ext[AW-1:0]),
        .rd_char (ram_rchar),
        .rd_attr (ram_rattr)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_read || is_null)
                        state_next = tcw_pkg::ST_DONE;
                    else if (is_newline || cur_full)
                        state_next = tcw_pkg::ST_BLANK;
                    else
                        state_next = tcw_pkg::ST_WRITE;
                end
            end
            tcw_pkg::ST_BLANK:
            begin
                if (sweep_last)
                    state_next = write_after_reg ? tcw_pkg::ST_WRITE : tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_WRITE:
            begin
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE:
            begin
                if (out_load)
                    state_next = tcw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // ram port and cursor controls
    always_comb
    begin
        cur_cmd   = '0;
        ram_we    = 1'b0;
        ram_waddr = sweep_addr_reg[AW-1:0];
        ram_wchar = tcw_pkg::BLANK_CHAR;
        ram_wattr = tcw_pkg::BLANK_ATTR;
        ram_re    = 1'b0;
        unique case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_read)
                        ram_re = 1'b1;
                    else if (is_null)
                        ram_re = 1'b0;
                    else if (is_newline)
                    begin
                        cur_cmd.home = row_past;
                        cur_cmd.jump = !row_past;
                    end
                    else
                        cur_cmd.home = cur_full;
                end
            end
            tcw_pkg::ST_BLANK:
            begin
                ram_we = 1'b1;
            end
            tcw_pkg::ST_WRITE:
            begin
                ram_we          = 1'b1;
                ram_waddr       = cursor[AW-1:0];
                ram_wchar       = code_reg;
                ram_wattr       = {high_nibble_reg, low_nibble_reg};
                cur_cmd.advance = 1'b1;
            end
            tcw_pkg::ST_DONE:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_nibble_reg <= tcw_pkg::HIGH_NIBBLE_RESET;
            low_nibble_reg  <= tcw_pkg::LOW_NIBBLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tcw_pkg::REG_HIGH_NIBBLE: high_nibble_reg <= cfg_data;
                tcw_pkg::REG_LOW_NIBBLE:  low_nibble_reg  <= cfg_data;
                default:                  high_nibble_reg <= high_nibble_reg;
            endcase
        end
    end

    // item context and blanking sweep range
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg        <= in_code;
            kind_reg        <= s_tuser;
            oob_reg         <= (32'(in_index) >= SCREEN_CELLS);
            write_after_reg <= !is_newline;
            if (is_newline && !row_past)
            begin
                sweep_addr_reg <= cursor;
                sweep_end_reg  <= next_row[CW-1:0];
            end
            else
            begin
                sweep_addr_reg <= '0;
                sweep_end_reg  <= CW'(SCREEN_CELLS);
            end
        end
        else if (state_reg == tcw_pkg::ST_BLANK)
        begin
            sweep_addr_reg <= sweep_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cursor_reg <= cursor_ext[10:0];
            if (kind_reg == tcw_pkg::KIND_READ && !oob_reg)
            begin
                out_char_reg <= ram_rchar;
                out_attr_reg <= ram_rattr;
            end
            else
            begin
                out_char_reg <= '0;
                out_attr_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_attr_reg, out_char_reg, out_cursor_reg};

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor <= CW'(SCREEN_CELLS))
        else $error("cursor beyond end of screen");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == tcw_pkg::ST_WRITE && cursor < CW'(SCREEN_CELLS))
                || (state_reg == tcw_pkg::ST_BLANK && sweep_addr_reg < sweep_end_reg))
        else $error("cell write outside the screen or sweep range");

    a_put_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && kind_reg == tcw_pkg::KIND_PUT |=> m_tdata[26:11] == 16'h0000)
        else $error("put result carries cell data");
`endif

endmodule

>>> hw/rtl/tcw_cell_ram.sv
module tcw_cell_ram #(
    parameter int SCREEN_CELLS = 2000,
    parameter int AW           = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_char,
    input  logic [7:0]    wr_attr,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_char,
    output logic [7:0]    rd_attr
);

    // character in the upper byte, attribute in the lower byte
    logic [15:0] mem [SCREEN_CELLS];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_char, wr_attr};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_char = rd_data_reg[15:8];
    assign rd_attr = rd_data_reg[7:0];

endmodule

>>> hw/rtl/tcw_cursor.sv
module tcw_cursor #(
    parameter int ROW_CELLS = 80,
    parameter int CW        = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcw_pkg::cursor_cmd_t cmd,
    output logic [CW-1:0]       cursor,
    output logic [CW:0]         next_row
);

    localparam int CLW = $clog2(ROW_CELLS);

    // row_base tracks cursor rounded down to a row start, so no divider is needed
    logic [CW-1:0]  cursor_reg,   cursor_next;
    logic [CW-1:0]  row_base_reg, row_base_next;
    logic [CLW-1:0] col_reg,      col_next;

    assign next_row = {1'b0, row_base_reg} + (CW + 1)'(ROW_CELLS);
    assign cursor   = cursor_reg;

    always_comb
    begin
        cursor_next   = cursor_reg;
        row_base_next = row_base_reg;
        col_next      = col_reg;
        priority if (cmd.home)
        begin
            cursor_next   = '0;
            row_base_next = '0;
            col_next      = '0;
        end
        else if (cmd.jump)
        begin
            cursor_next   = next_row[CW-1:0];
            row_base_next = next_row[CW-1:0];
            col_next      = '0;
        end
        else if (cmd.advance)
        begin
            cursor_next = cursor_reg + 1'b1;
            if (col_reg == CLW'(ROW_CELLS - 1))
            begin
                col_next      = '0;
                row_base_next = next_row[CW-1:0];
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            row_base_reg <= '0;
            col_reg      <= '0;
        end
        else
        begin
            cursor_reg   <= cursor_next;
            row_base_reg <= row_base_next;
            col_reg      <= col_next;
        end
    end

endmodule
